[rtl/mrp_pkg.sv]
// Package with shared types and constants for the Miller-Rabin primality tester.
`timescale 1ns / 1ps
`default_nettype none
package mrp_pkg;
    localparam int unsigned DefWidth = 32;
    localparam int unsigned NWidth = 32;
    localparam int unsigned RandWidth = 31;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_check,
        t_st_rmod,
        t_st_split,
        t_st_pow_mul,
        t_st_pow_sq,
        t_st_test,
        t_st_sq,
        t_st_sq_test,
        t_st_done
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_mul_ctrl;
endpackage
`default_nettype wire

[rtl/mrp_modmul.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle using modular doubling and adding.
`timescale 1ns / 1ps
`default_nettype none
module mrp_modmul #(
    parameter int unsigned WIDTH = mrp_pkg::DefWidth
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mrp_pkg::t_mul_ctrl i_ctrl,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_m,
    output logic      [WIDTH-1:0] o_p,
    output logic                  o_done
);
    import mrp_pkg::*;

    logic [WIDTH-1:0] r_acc, n_acc, r_x, n_x, r_y, n_y;
    logic             r_run, n_run, r_done, n_done;
    logic [WIDTH:0]   w_sum, w_dbl;

    // x and acc stay below m, so one conditional subtract brings each sum back.
    always_comb begin
        w_sum = {1'b0, r_acc} + {1'b0, r_x};
        w_dbl = {1'b0, r_x} + {1'b0, r_x};
        n_acc = r_acc;
        n_x = r_x;
        n_y = r_y;
        n_run = r_run;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_acc = '0;
            n_x = i_x;
            n_y = i_y;
            n_run = 1'b1;
        end else if (r_run) begin
            if (r_y == '0) begin
                n_run = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_y[0]) begin
                    n_acc = (w_sum >= {1'b0, i_m}) ? WIDTH'(w_sum - {1'b0, i_m})
                                                   : WIDTH'(w_sum);
                end
                n_x = (w_dbl >= {1'b0, i_m}) ? WIDTH'(w_dbl - {1'b0, i_m}) : WIDTH'(w_dbl);
                n_y = r_y >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run <= n_run;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_p = r_acc;
    assign o_done = r_done;
endmodule
`default_nettype wire

[rtl/miller_rabin_primality.sv]
// Top level of the Miller-Rabin primality tester with sequencer and witness datapath.
// The random value is reduced bit-serially to the witness; each modular multiply is bit-serial
// and a witness needs at most 2*WIDTH of them.
// Throughput: one request at a time; a waiting result stalls only a later last request.
// Trivial candidates (below five or even) go from the check state straight to the done state.
// Reset is synchronous, active low, and clears the sequencer, the composite flag and o_valid.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_primality #(
    parameter int unsigned WIDTH = mrp_pkg::DefWidth
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [mrp_pkg::NWidth-1:0]    i_n_value,
    input  wire logic [mrp_pkg::RandWidth-1:0] i_random_value,
    input  wire logic                          i_last_witness,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_probably_prime
);
    import mrp_pkg::*;

    localparam int unsigned RW = (RandWidth > WIDTH) ? RandWidth : WIDTH;
    localparam int unsigned CntW = $clog2(RW + 1);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_n, r_nm1, r_d, r_acc, r_b, r_rem, r_nm3;
    logic [RW-1:0]    r_rnd;
    logic [CntW-1:0]  r_cnt, r_s;
    logic             r_last, r_comp, r_ovalid, r_oprime, r_wcomp;
    logic             w_trivial, w_tcomp, w_hold;
    t_mul_ctrl        w_mc;
    logic [WIDTH-1:0] w_mx, w_my, w_p;
    logic             w_mdone;
    logic [WIDTH:0]   w_rs;
    logic [WIDTH-1:0] w_nin;

    assign w_nin = WIDTH'(i_n_value);
    assign w_rs = {r_rem, r_rnd[RW-1]};

    mrp_modmul #(.WIDTH(WIDTH)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_mc),
        .i_x(w_mx), .i_y(w_my), .i_m(r_n), .o_p(w_p), .o_done(w_mdone)
    );

    always_comb begin
        w_trivial = (r_n < WIDTH'(5)) || !r_n[0];
        w_tcomp = (r_n < WIDTH'(2)) || (!r_n[0] && r_n != WIDTH'(2));
        w_hold = r_last && r_ovalid && !i_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_st_idle:    if (i_valid) n_state = t_st_check;
            t_st_check:   n_state = w_trivial ? t_st_done : t_st_rmod;
            t_st_rmod:    if (r_cnt == '0) n_state = t_st_split;
            t_st_split:   if (r_d[0]) n_state = t_st_pow_mul;
            t_st_pow_mul: if (w_mdone) n_state = t_st_pow_sq;
            t_st_pow_sq:  if (w_mdone) n_state = (r_d[WIDTH-1:1] == '0) ? t_st_test
                                                                         : t_st_pow_mul;
            t_st_test:    n_state = (r_acc == WIDTH'(1) || r_acc == r_nm1 || r_s <= CntW'(1))
                                    ? t_st_done : t_st_sq;
            t_st_sq:      if (w_mdone) n_state = t_st_sq_test;
            t_st_sq_test: n_state = (r_acc == r_nm1 || r_s <= CntW'(1)) ? t_st_done : t_st_sq;
            t_st_done:    n_state = w_hold ? t_st_done : t_st_idle;
            default:      n_state = t_st_idle;
        endcase
    end

    always_comb begin
        w_mc.start = 1'b0;
        w_mc.busy = 1'b0;
        w_mx = r_acc;
        w_my = r_b;
        unique case (r_state)
            t_st_pow_mul: begin
                w_mc.busy = 1'b1;
                w_mc.start = (r_cnt == '0);
            end
            t_st_pow_sq: begin
                w_mc.busy = 1'b1;
                w_mc.start = (r_cnt == '0);
                w_mx = r_b;
            end
            t_st_sq: begin
                w_mc.busy = 1'b1;
                w_mc.start = (r_cnt == '0);
                w_my = r_acc;
            end
            default: w_mc.busy = 1'b0;
        endcase
        if (!w_mc.busy) w_mc.start = 1'b0;
    end

    assign o_ready = (r_state == t_st_idle);
    assign o_valid = r_ovalid;
    assign o_probably_prime = r_oprime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
            r_comp <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == t_st_done && !w_hold && r_last) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == t_st_done && !w_hold) begin
                if (r_last) begin
                    r_oprime <= !(r_comp || r_wcomp);
                    r_comp <= 1'b0;
                end else begin
                    r_comp <= r_comp || r_wcomp;
                end
            end
        end
        unique case (r_state)
            t_st_idle: begin
                r_n <= w_nin;
                r_rnd <= RW'(i_random_value);
                r_last <= i_last_witness;
            end
            t_st_check: begin
                r_wcomp <= w_tcomp;
                r_nm1 <= r_n - WIDTH'(1);
                r_nm3 <= r_n - WIDTH'(3);
                r_rem <= '0;
                r_cnt <= CntW'(RW);
            end
            t_st_rmod: begin
                // Restoring remainder, one random bit per cycle.
                if (r_cnt != '0) begin
                    r_rem <= (w_rs >= {1'b0, r_nm3}) ? WIDTH'(w_rs - {1'b0, r_nm3})
                                                     : WIDTH'(w_rs);
                    r_rnd <= r_rnd << 1;
                    r_cnt <= r_cnt - CntW'(1);
                end else begin
                    r_b <= r_rem + WIDTH'(2);
                    r_d <= r_nm1;
                    r_s <= '0;
                    r_acc <= WIDTH'(1);
                end
            end
            t_st_split: begin
                if (!r_d[0]) begin
                    r_d <= r_d >> 1;
                    r_s <= r_s + CntW'(1);
                end
            end
            t_st_pow_mul: begin
                if (r_cnt == '0) r_cnt <= CntW'(1);
                if (w_mdone) begin
                    if (r_d[0]) r_acc <= w_p;
                    r_cnt <= '0;
                end
            end
            t_st_pow_sq: begin
                if (r_cnt == '0) r_cnt <= CntW'(1);
                if (w_mdone) begin
                    r_b <= w_p;
                    r_d <= r_d >> 1;
                    r_cnt <= '0;
                end
            end
            t_st_test: begin
                r_wcomp <= !(r_acc == WIDTH'(1) || r_acc == r_nm1);
                r_s <= r_s - CntW'(1);
                r_cnt <= '0;
            end
            t_st_sq: begin
                if (r_cnt == '0) r_cnt <= CntW'(1);
                if (w_mdone) begin
                    r_acc <= w_p;
                    r_cnt <= '0;
                end
            end
            t_st_sq_test: begin
                r_s <= r_s - CntW'(1);
                if (r_acc == r_nm1) r_wcomp <= 1'b0;
            end
            default: r_cnt <= r_cnt;
        endcase
    end
endmodule
`default_nettype wire

[rtl/mrp_checker.sv]
// Port-level assertion checker for the Miller-Rabin primality tester, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mrp_port_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_probably_prime
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_probably_prime))
        else $error("result dropped or changed while stalled");
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared while idle");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after a request");
endmodule

bind miller_rabin_primality mrp_port_checker u_mrp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_probably_prime(o_probably_prime)
);
`default_nettype wire

[verif/mrp_checker.sv]
// Checker that predicts and compares the verdicts of the Miller-Rabin primality tester.
`timescale 1ns / 1ps
module mrp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_n_value,
    input  logic [30:0] i_random_value,
    input  logic        i_last_witness,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_probably_prime,
    output int          o_errors,
    output int          o_pending
);
    bit verdict_queue[$];
    bit run_composite;

    function automatic bit [63:0] modmul(bit [63:0] x, bit [63:0] y, bit [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic bit witness_proves_composite(bit [63:0] n, bit [63:0] rnd);
        bit [63:0] nm1;
        bit [63:0] d;
        bit [63:0] x;
        bit [63:0] b;
        int s;
        if (n < 2) return 1'b1;
        if (n == 2 || n == 3) return 1'b0;
        if (n[0] == 1'b0) return 1'b1;
        nm1 = n - 1;
        d = nm1;
        s = 0;
        while (d[0] == 1'b0 && d != 0) begin
            d = d >> 1;
            s++;
        end
        b = (2 + rnd % (n - 3)) % n;
        x = 1;
        while (d != 0) begin
            if (d[0]) x = modmul(x, b, n);
            b = modmul(b, b, n);
            d = d >> 1;
        end
        if (x == 1 || x == nm1) return 1'b0;
        for (int r = 1; r < s; r++) begin
            x = modmul(x, x, n);
            if (x == nm1) return 1'b0;
        end
        return 1'b1;
    endfunction

    assign o_pending = verdict_queue.size();

    initial begin
        o_errors = 0;
        run_composite = 1'b0;
    end

    always @(posedge i_clk) begin
        bit want;
        bit comp;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                comp = run_composite |
                       witness_proves_composite(64'(i_n_value), 64'(i_random_value));
                if (i_last_witness) begin
                    verdict_queue.push_back(!comp);
                    run_composite = 1'b0;
                end else begin
                    run_composite = comp;
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual %0b",
                             $time, i_probably_prime);
                    o_errors++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (want !== i_probably_prime) begin
                        $display("%0t: probably_prime mismatch, expected %0b, actual %0b",
                                 $time, want, i_probably_prime);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

[verif/testbench.sv]
// Top of the testbench: clock, reset, request and verdict traffic, and the final verdict.
`timescale 1ns / 1ps
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_n_value;
    logic [30:0] i_random_value;
    logic        i_last_witness;
    logic        o_valid;
    logic        i_ready;
    logic        o_probably_prime;
    int          errors;
    int          pending;
    bit          idle_on;
    bit          hold_req;
    int unsigned prime_list[8] = '{5, 7, 97, 7919, 65521, 1000000007,
                                   2147483647, 32'hFFFFFFFB};

    miller_rabin_primality u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_n_value(i_n_value), .i_random_value(i_random_value),
        .i_last_witness(i_last_witness), .o_valid(o_valid), .i_ready(i_ready),
        .o_probably_prime(o_probably_prime)
    );

    mrp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_valid), .i_req_ready(o_ready),
        .i_n_value(i_n_value), .i_random_value(i_random_value),
        .i_last_witness(i_last_witness), .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_probably_prime(o_probably_prime), .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    task automatic send_request(input logic [31:0] n, input logic [30:0] rnd, input bit last);
        if (idle_on && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_n_value <= n;
        i_random_value <= rnd;
        i_last_witness <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_run(input logic [31:0] n, input int witnesses);
        for (int k = 0; k < witnesses; k++)
            send_request(n, 31'($urandom), k == witnesses - 1);
    endtask

    function automatic logic [31:0] pick_candidate();
        case ($urandom_range(5))
            0: return prime_list[$urandom_range(7)];
            1: return $urandom | 32'h1;
            2: return $urandom_range(0, 200);
            3: return ($urandom & 32'hFFFF) | 32'h1;
            4: return 32'd561;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int sent;
        int cnt;
        logic [31:0] n;
        idle_on = 1'b1;
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_n_value <= '0;
        i_random_value <= '0;
        i_last_witness <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(32'd0, 31'd0, 1'b1);
        send_request(32'd1, 31'h7FFFFFFF, 1'b1);
        send_request(32'd2, 31'd5, 1'b1);
        send_request(32'd3, 31'd9, 1'b1);
        send_request(32'd4, 31'd1, 1'b1);
        send_request(32'd5, 31'd0, 1'b0);
        send_request(32'd5, 31'h7FFFFFFF, 1'b1);
        send_request(32'hFFFFFFFF, 31'h7FFFFFFF, 1'b1);
        send_request(32'hFFFFFFFE, 31'd3, 1'b1);
        send_request(32'hFFFFFFFB, 31'd0, 1'b0);
        send_request(32'hFFFFFFFB, 31'h7FFFFFFF, 1'b1);
        send_request(32'd561, 31'd0, 1'b0);
        send_request(32'd561, 31'h55555555, 1'b0);
        send_request(32'd561, 31'h2AAAAAAA, 1'b1);
        send_request(32'd2, 31'd0, 1'b0);
        send_request(32'd9, 31'd1, 1'b1);
        send_request(32'd7, 31'd4, 1'b0);
        send_request(32'd3, 31'd4, 1'b1);

        // The receiver stops while short requests keep arriving.
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            send_request(($urandom_range(2, 1000) & ~32'h1), 31'($urandom), (k % 2) == 1);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        sent = 0;
        while (sent < 600) begin
            if (sent > 500) idle_on = 1'b0;
            n = pick_candidate();
            cnt = $urandom_range(1, 5);
            if ($urandom_range(9) == 0) begin
                for (int k = 0; k < cnt; k++)
                    send_request(pick_candidate(), 31'($urandom), $urandom_range(3) == 0);
            end else begin
                send_run(n, cnt);
            end
            sent += cnt;
        end
        send_request(32'd3, 31'd0, 1'b1);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
